// File: hw/rtl/cstr_pkg.sv
// Shared types and constants for the client slot table.
package cstr_pkg;

	localparam int NUM_SLOTS_DEF = 8;

	localparam logic [7:0] MSG_ID_INIT    = 8'hA0;
	localparam logic [7:0] FAIL_LIMIT_RST = 8'd5;
	localparam logic [7:0] FAILS_MAX      = 8'hFF;

	localparam logic [3:0] FN_ADD       = 4'd0;
	localparam logic [3:0] FN_REMOVE    = 4'd1;
	localparam logic [3:0] FN_SELECT    = 4'd2;
	localparam logic [3:0] FN_DROP_CUR  = 4'd3;
	localparam logic [3:0] FN_NEXT      = 4'd4;
	localparam logic [3:0] FN_FAIL      = 4'd5;
	localparam logic [3:0] FN_CLR_FAILS = 4'd6;
	localparam logic [3:0] FN_LOOKUP    = 4'd7;
	localparam logic [3:0] FN_RST_MSG   = 4'd8;

	typedef struct packed {
		logic [15:0] id;
		logic [7:0]  fails;
		logic [7:0]  msg_id;
	} entry_t;

	typedef struct packed {
		logic match;
		logic free;
		logic next;
	} scan_flags_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_ACT,
		ST_READ,
		ST_WAIT
	} state_t;

endpackage

// File: hw/rtl/cstr_table.sv
// Slot table memory with per-entry valid bits; unwritten entries read as zero.
module cstr_table import cstr_pkg::*; #(
	parameter int DEPTH = NUM_SLOTS_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data
);

	entry_t           mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	entry_t           rd_data_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

// File: hw/rtl/cstr_scan.sv
// Scan accumulator: id match, first free slot, current entry and next occupied slot.
module cstr_scan import cstr_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF,
	parameter int IW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clr,
	input  logic          vld,
	input  logic [IW-1:0] idx,
	input  entry_t        ent,
	input  logic [15:0]   key,
	input  logic [IW-1:0] cursor,
	output scan_flags_t   flags,
	output logic [IW-1:0] match_idx,
	output entry_t        match_ent,
	output logic [IW-1:0] free_idx,
	output entry_t        free_ent,
	output entry_t        cur_ent,
	output logic [IW-1:0] next_idx
);

	logic          match_q, free_q, after_q, any_q;
	logic [IW-1:0] match_idx_q, free_idx_q, after_idx_q, any_idx_q;
	entry_t        match_ent_q, free_ent_q, cur_ent_q;
	logic          hit, empty, occ;

	assign hit   = vld && (key != 16'd0) && (ent.id == key);
	assign empty = vld && (ent.id == 16'd0);
	assign occ   = vld && (ent.id != 16'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			free_q  <= 1'b0;
			after_q <= 1'b0;
			any_q   <= 1'b0;
		end else if (clr) begin
			match_q <= 1'b0;
			free_q  <= 1'b0;
			after_q <= 1'b0;
			any_q   <= 1'b0;
		end else begin
			if (hit) match_q <= 1'b1;
			if (empty) free_q <= 1'b1;
			if (occ && (idx > cursor)) after_q <= 1'b1;
			if (occ) any_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (hit && !match_q) begin
			match_idx_q <= idx;
			match_ent_q <= ent;
		end
		if (empty && !free_q) begin
			free_idx_q <= idx;
			free_ent_q <= ent;
		end
		if (occ && (idx > cursor) && !after_q) begin
			after_idx_q <= idx;
		end
		if (occ && !any_q) begin
			any_idx_q <= idx;
		end
		if (vld && (idx == cursor)) begin
			cur_ent_q <= ent;
		end
	end

	assign flags.match = match_q;
	assign flags.free  = free_q;
	assign flags.next  = after_q || any_q;
	assign match_idx   = match_idx_q;
	assign match_ent   = match_ent_q;
	assign free_idx    = free_idx_q;
	assign free_ent    = free_ent_q;
	assign cur_ent     = cur_ent_q;
	assign next_idx    = after_q ? after_idx_q : any_idx_q;

endmodule

// File: hw/rtl/client_slot_table_round_robin.sv
// Client slot table with round-robin cursor: sequencer, command logic and output register.
// Steps per word: a table scan of one entry per cycle, a drain step, one write and one
// read-back of the current slot on the single table port pair, then the output register load.
// A new word is accepted only once the previous result has been loaded into the output register.
// Reset: every slot free, cursor and client count zero, fail_limit 5, no result pending.
module client_slot_table_round_robin import cstr_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  func,
	input  logic [15:0] client_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ok,
	output logic [15:0] current_id,
	output logic        current_valid,
	output logic [2:0]  current_slot,
	output logic [3:0]  client_count,
	output logic [7:0]  current_fails,
	output logic [7:0]  current_msg_id
);

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);

	state_t        state_q, state_d;
	logic [3:0]    func_q;
	logic [15:0]   key_q;
	logic [7:0]    lim_q;
	logic [IW-1:0] cur_q, cur_d;
	logic [CW-1:0] cnt_q, cnt_d, cnt_dec;
	logic          ok_q, ok_d;
	logic [IW-1:0] scan_cnt_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;

	logic          accept, scan_last, act_en, out_load;
	logic          mem_rd_en, we_c;
	logic [IW-1:0] mem_rd_addr, wr_addr_c;
	entry_t        wr_data_c, rd_data;
	logic [7:0]    nf;

	scan_flags_t   flags;
	logic [IW-1:0] match_idx, free_idx, next_idx;
	entry_t        match_ent, free_ent, cur_ent;

	logic          out_valid_q, ok_o_q, cur_valid_o_q;
	logic [15:0]   cur_id_o_q;
	logic [2:0]    cur_slot_o_q;
	logic [3:0]    cnt_o_q;
	logic [7:0]    fails_o_q, msg_o_q;
	logic [31:0]   cur_ext, cnt_ext;

	assign accept    = in_valid && in_ready;
	assign scan_last = (scan_cnt_q == IW'(NUM_SLOTS - 1));

	cstr_table #(
		.DEPTH (NUM_SLOTS),
		.AW    (IW)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (act_en && we_c),
		.wr_addr (wr_addr_c),
		.wr_data (wr_data_c),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (rd_data)
	);

	cstr_scan #(
		.NUM_SLOTS (NUM_SLOTS),
		.IW        (IW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (accept),
		.vld       (vld_s1),
		.idx       (idx_s1),
		.ent       (rd_data),
		.key       (key_q),
		.cursor    (cur_q),
		.flags     (flags),
		.match_idx (match_idx),
		.match_ent (match_ent),
		.free_idx  (free_idx),
		.free_ent  (free_ent),
		.cur_ent   (cur_ent),
		.next_idx  (next_idx)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_SCAN;
			ST_SCAN:  if (scan_last) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_ACT;
			ST_ACT:   state_d = ST_READ;
			ST_READ:  state_d = ST_WAIT;
			ST_WAIT:  if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready    = 1'b0;
		mem_rd_en   = 1'b0;
		mem_rd_addr = scan_cnt_q;
		act_en      = 1'b0;
		out_load    = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_SCAN: mem_rd_en = 1'b1;
			ST_ACT:  act_en = 1'b1;
			ST_READ: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = cur_q;
			end
			ST_WAIT: out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// command logic
	always_comb begin
		we_c      = 1'b0;
		wr_addr_c = cur_q;
		wr_data_c = cur_ent;
		cur_d     = cur_q;
		cnt_dec   = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;
		cnt_d     = cnt_q;
		ok_d      = 1'b0;
		nf        = (cur_ent.fails == FAILS_MAX) ? cur_ent.fails : cur_ent.fails + 8'd1;
		case (func_q)
			FN_ADD: begin
				if (flags.match) begin
					we_c             = 1'b1;
					wr_addr_c        = match_idx;
					wr_data_c        = match_ent;
					wr_data_c.msg_id = MSG_ID_INIT;
				end else if (key_q != 16'd0 && cnt_q < CW'(NUM_SLOTS) && flags.free) begin
					we_c             = 1'b1;
					wr_addr_c        = free_idx;
					wr_data_c        = free_ent;
					wr_data_c.id     = key_q;
					wr_data_c.msg_id = MSG_ID_INIT;
					cnt_d            = cnt_q + 1'b1;
					ok_d             = 1'b1;
				end
			end
			FN_REMOVE: begin
				if (flags.match) begin
					we_c         = 1'b1;
					wr_addr_c    = match_idx;
					wr_data_c    = match_ent;
					wr_data_c.id = 16'd0;
					cnt_d        = cnt_dec;
					ok_d         = 1'b1;
				end
			end
			FN_SELECT: begin
				if (flags.match) begin
					cur_d = match_idx;
					ok_d  = 1'b1;
				end
			end
			FN_DROP_CUR: begin
				if (cur_ent.id != 16'd0) begin
					we_c         = 1'b1;
					wr_data_c.id = 16'd0;
					cnt_d        = cnt_dec;
					ok_d         = 1'b1;
				end
			end
			FN_NEXT: begin
				if (cnt_q != '0 && flags.next) begin
					cur_d = next_idx;
					ok_d  = 1'b1;
				end
			end
			FN_FAIL: begin
				we_c            = 1'b1;
				wr_data_c.fails = nf;
				if (nf > lim_q && cur_ent.id != 16'd0) begin
					wr_data_c.id = 16'd0;
					cnt_d        = cnt_dec;
					ok_d         = 1'b1;
				end
			end
			FN_CLR_FAILS: begin
				we_c            = 1'b1;
				wr_data_c.fails = 8'd0;
				ok_d            = cur_ent.id != 16'd0;
			end
			FN_LOOKUP: ok_d = flags.match;
			FN_RST_MSG: begin
				if (flags.match) begin
					we_c             = 1'b1;
					wr_addr_c        = match_idx;
					wr_data_c        = match_ent;
					wr_data_c.msg_id = MSG_ID_INIT;
					ok_d             = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lim_q       <= FAIL_LIMIT_RST;
			cur_q       <= '0;
			cnt_q       <= '0;
			scan_cnt_q  <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) lim_q <= cfg_wr_data;
			if (act_en) begin
				cur_q <= cur_d;
				cnt_q <= cnt_d;
			end
			if (accept) begin
				scan_cnt_q <= '0;
			end else if (state_q == ST_SCAN) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
			vld_s1 <= (state_q == ST_SCAN);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign cur_ext = 32'(cur_q);
	assign cnt_ext = 32'(cnt_q);

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			key_q  <= client_id;
		end
		idx_s1 <= scan_cnt_q;
		if (act_en) ok_q <= ok_d;
		if (out_load) begin
			ok_o_q        <= ok_q;
			cur_id_o_q    <= rd_data.id;
			cur_valid_o_q <= rd_data.id != 16'd0;
			cur_slot_o_q  <= cur_ext[2:0];
			cnt_o_q       <= cnt_ext[3:0];
			fails_o_q     <= rd_data.fails;
			msg_o_q       <= rd_data.msg_id;
		end
	end

	assign out_valid      = out_valid_q;
	assign ok             = ok_o_q;
	assign current_id     = cur_id_o_q;
	assign current_valid  = cur_valid_o_q;
	assign current_slot   = cur_slot_o_q;
	assign client_count   = cnt_o_q;
	assign current_fails  = fails_o_q;
	assign current_msg_id = msg_o_q;

endmodule
